/* sv/fffa_pkg.sv */
// Shared types and constants for the FIFO free-list frame allocator.
// No dependencies; every other file refers to it by scoped names.
package fffa_pkg;

  localparam int unsigned MaxFrames = 1024;
  localparam int unsigned FrameW    = $clog2(MaxFrames);
  localparam int unsigned CountW    = FrameW + 1;

  localparam logic [CountW-1:0] MaxFramesC = CountW'(MaxFrames);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // One write port and one registered read port of a memory.
  typedef struct packed {
    logic              we;
    logic [FrameW-1:0] waddr;
    logic              re;
    logic [FrameW-1:0] raddr;
  } mem_ctl_t;

endpackage

/* sv/fffa_ram.sv */
// Generic single-clock RAM: one write port, one registered read port.
// Uses fffa_pkg for the port control struct.
module fffa_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  logic                              clk_i,
  input  fffa_pkg::mem_ctl_t                ctl_i,
  input  logic [Width-1:0]                  wdata_i,
  output logic [Width-1:0]                  rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_o <= mem_q[ctl_i.raddr];
    end
  end

endmodule

/* sv/fifo_free_frame_allocator_unit.sv */
// Top level of the FIFO free-list page-frame allocator.
// Depends on fffa_pkg and fffa_ram (used-bit memory and freed-frame queue memory).
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------------------
//  command   | in        | start_i, busy_o           | opcode_i, frame_index_i
//  result    | out       | done_o (one-cycle strobe) | frame_out_o, status_o, frame_free_o,
//            |           |                           | free_count_o
//  config    | in        | cfg_valid_i, cfg_ready_o  | cfg_data_i (total frames)
//
// On acceptance the unit launches the reads of the used-bit memory and of the queue
// head entry; in the execute state it does the read-modify-write and registers the
// result. done_o is high in the cycle after that, when busy_o is already low again,
// so a new word can be taken while done_o is high, but not during the execute state.
// Reset and any configuration write clear the counters only: a used bit counts only
// for frames below the fresh-frame counter, so no memory sweep is needed.
// The receiver cannot stall; results are never held.
module fifo_free_frame_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic [fffa_pkg::FrameW-1:0]   frame_index_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fffa_pkg::CountW-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [fffa_pkg::CountW-1:0]   frame_out_o,
  output logic [1:0]                    status_o,
  output logic                          frame_free_o,
  output logic [fffa_pkg::CountW-1:0]   free_count_o
);

  localparam int unsigned FW = fffa_pkg::FrameW;
  localparam int unsigned CW = fffa_pkg::CountW;

  fffa_pkg::state_e state_q, state_d;

  // Control state.
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic [FW-1:0] head_q, head_d;
  logic [FW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  // Latched command word.
  fffa_pkg::op_e op_q;
  logic [FW-1:0] idx_q;

  // Result registers.
  logic                done_q;
  logic [CW-1:0]       frame_q, frame_d;
  fffa_pkg::status_e   status_q, status_d;
  logic                free_q, free_d;
  logic [CW-1:0]       fcount_q, fcount_d;

  // Memory ports.
  fffa_pkg::mem_ctl_t used_ctl, queue_ctl;
  logic               used_wdata, used_rdata;
  logic [FW-1:0]      queue_rdata;

  logic          accept;
  logic          cfg_write;
  logic [CW-1:0] total_eff;
  logic          in_range;
  logic          is_used;
  logic [CW-1:0] fresh_left;

  assign busy_o      = (state_q != fffa_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == fffa_pkg::S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Clamp an oversized total to the memory depth.
  assign total_eff = (total_q > fffa_pkg::MaxFramesC) ? fffa_pkg::MaxFramesC : total_q;
  assign in_range  = ({1'b0, idx_q} < total_eff);
  // Frames at or above the fresh counter were never handed out since the last clear.
  assign is_used   = ({1'b0, idx_q} < fresh_q) && used_rdata;

  fffa_ram #(
    .Width (1),
    .Depth (fffa_pkg::MaxFrames)
  ) u_used_ram (
    .clk_i   (clk_i),
    .ctl_i   (used_ctl),
    .wdata_i (used_wdata),
    .rdata_o (used_rdata)
  );

  fffa_ram #(
    .Width (FW),
    .Depth (fffa_pkg::MaxFrames)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .ctl_i   (queue_ctl),
    .wdata_i (idx_q),
    .rdata_o (queue_rdata)
  );

  // Read-modify-write of one operation in the execute cycle.
  always_comb begin
    state_d        = state_q;
    total_d        = total_q;
    fresh_d        = fresh_q;
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    frame_d        = fffa_pkg::MaxFramesC;
    status_d       = fffa_pkg::ST_OK;
    free_d         = 1'b0;
    // Launch both reads at the accept edge.
    used_ctl.re     = accept;
    used_ctl.raddr  = frame_index_i;
    queue_ctl.re    = accept;
    queue_ctl.raddr = head_q;
    used_ctl.we    = 1'b0;
    used_ctl.waddr = idx_q;
    used_wdata     = 1'b0;
    queue_ctl.we   = 1'b0;
    queue_ctl.waddr = tail_q;

    unique case (state_q)
      fffa_pkg::S_IDLE: begin
        if (cfg_write) begin
          // New total: every frame is free again.
          total_d = cfg_data_i;
          fresh_d = '0;
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        if (accept) begin
          state_d = fffa_pkg::S_EXEC;
        end
      end
      fffa_pkg::S_EXEC: begin
        state_d = fffa_pkg::S_IDLE;
        unique case (op_q)
          fffa_pkg::OP_ALLOC: begin
            if (fresh_q < total_eff) begin
              frame_d        = fresh_q;
              fresh_d        = fresh_q + CW'(1);
              used_ctl.we    = 1'b1;
              used_ctl.waddr = fresh_q[FW-1:0];
              used_wdata     = 1'b1;
            end else if (count_q != '0) begin
              frame_d        = {1'b0, queue_rdata};
              head_d         = head_q + FW'(1);
              count_d        = count_q - CW'(1);
              used_ctl.we    = 1'b1;
              used_ctl.waddr = queue_rdata;
              used_wdata     = 1'b1;
            end else begin
              status_d = fffa_pkg::ST_EMPTY;
            end
          end
          fffa_pkg::OP_FREE: begin
            if (!in_range) begin
              status_d = fffa_pkg::ST_RANGE;
            end else if (!is_used) begin
              status_d = fffa_pkg::ST_ALREADY;
            end else if (count_q < fffa_pkg::MaxFramesC) begin
              used_ctl.we  = 1'b1;
              used_wdata   = 1'b0;
              queue_ctl.we = 1'b1;
              tail_d       = tail_q + FW'(1);
              count_d      = count_q + CW'(1);
            end
          end
          fffa_pkg::OP_QUERY: begin
            if (!in_range) begin
              status_d = fffa_pkg::ST_RANGE;
            end else begin
              free_d = !is_used;
            end
          end
          fffa_pkg::OP_NOP: begin
            // Report the free count only.
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = fffa_pkg::S_IDLE;
      end
    endcase

    fresh_left = (fresh_d < total_eff) ? (total_eff - fresh_d) : '0;
    fcount_d   = fresh_left + count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fffa_pkg::S_IDLE;
      total_q <= fffa_pkg::MaxFramesC;
      fresh_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= (state_q == fffa_pkg::S_EXEC);
    end
  end

  // Hold the command word and the result; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= fffa_pkg::op_e'(opcode_i);
      idx_q <= frame_index_i;
    end
    if (state_q == fffa_pkg::S_EXEC) begin
      frame_q  <= frame_d;
      status_q <= status_d;
      free_q   <= free_d;
      fcount_q <= fcount_d;
    end
  end

  assign done_o       = done_q;
  assign frame_out_o  = frame_q;
  assign status_o     = status_q;
  assign frame_free_o = free_q;
  assign free_count_o = fcount_q;

  // Every execute cycle yields exactly one result strobe.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fffa_pkg::S_EXEC) |=> done_o)
    else $error("execute cycle without result strobe");

  // A result is only shown after an execute cycle.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == fffa_pkg::S_EXEC))
    else $error("result strobe without execute cycle");

  // The freed-frame queue never holds more than the memory depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fffa_pkg::MaxFramesC)
    else $error("queue count overflow");

  // A failed allocation must leave no free frame.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == fffa_pkg::ST_EMPTY)) |-> (free_count_o == '0))
    else $error("allocation failed with free frames left");

endmodule
